FILE: rtl/core/rmdu_pkg.sv
// Package: constants, microcode types and program ROM for the running statistics unit.
`default_nettype none
package rmdu_pkg;

  localparam int unsigned FRAC_BITS_DEF   = 16;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned VAL_BITS        = 40;
  localparam int unsigned CNT_BITS        = 32;
  localparam int unsigned CFG_BITS        = 32;
  localparam int unsigned WIDE_BITS       = 128;
  localparam int unsigned PC_BITS         = 5;
  localparam int unsigned ITER_BITS       = 7;

  localparam logic [VAL_BITS-1:0] VAL_MAX = {VAL_BITS{1'b1}};
  localparam logic [CNT_BITS-1:0] CNT_MAX = {CNT_BITS{1'b1}};

  localparam logic [ITER_BITS-1:0] MUL_LAST  = ITER_BITS'(VAL_BITS - 1);
  localparam logic [ITER_BITS-1:0] DIV_LAST  = ITER_BITS'(WIDE_BITS - 1);
  localparam logic [ITER_BITS-1:0] SQRT_LAST = ITER_BITS'(WIDE_BITS / 2 - 1);

  typedef enum logic [1:0] {
    REG_PRIOR_COUNT = 2'd0,
    REG_PRIOR_MEAN  = 2'd1,
    REG_PRIOR_HARM  = 2'd2,
    REG_PRIOR_DEV   = 2'd3
  } reg_idx_e;

  typedef enum logic [3:0] {
    OP_INIT, OP_MUL, OP_DIV, OP_SQRT, OP_ADD, OP_SUBZ,
    OP_SATM, OP_SATH, OP_JNH, OP_DONE
  } op_e;

  typedef enum logic [3:0] {
    S_T0, S_T1, S_T2, S_T3, S_MEAN, S_DEV, S_HARM, S_N, S_M1, S_XQ, S_NM
  } src_e;

  typedef enum logic [1:0] {
    D_T0, D_T1, D_T2, D_T3
  } dst_e;

  typedef struct packed {
    op_e                op;
    src_e               a;
    src_e               b;
    dst_e               dst;
    logic [PC_BITS-1:0] target;
  } uop_t;

  localparam logic [PC_BITS-1:0] PC_DONE = PC_BITS'(23);

  function automatic uop_t ucode(input logic [PC_BITS-1:0] pc);
    uop_t u;
    u = '{op: OP_DONE, a: S_T0, b: S_T0, dst: D_T0, target: '0};
    unique case (pc)
      5'd0:  u.op = OP_INIT;
      5'd1:  u = '{op: OP_MUL,  a: S_MEAN, b: S_M1,   dst: D_T0, target: '0};
      5'd2:  u = '{op: OP_ADD,  a: S_T0,   b: S_XQ,   dst: D_T0, target: '0};
      5'd3:  u = '{op: OP_DIV,  a: S_T0,   b: S_N,    dst: D_T0, target: '0};
      5'd4:  u = '{op: OP_SATM, a: S_T0,   b: S_T0,   dst: D_T0, target: '0};
      5'd5:  u = '{op: OP_MUL,  a: S_DEV,  b: S_DEV,  dst: D_T0, target: '0};
      5'd6:  u = '{op: OP_MUL,  a: S_MEAN, b: S_MEAN, dst: D_T1, target: '0};
      5'd7:  u = '{op: OP_ADD,  a: S_T0,   b: S_T1,   dst: D_T0, target: '0};
      5'd8:  u = '{op: OP_MUL,  a: S_T0,   b: S_M1,   dst: D_T0, target: '0};
      5'd9:  u = '{op: OP_MUL,  a: S_XQ,   b: S_XQ,   dst: D_T1, target: '0};
      5'd10: u = '{op: OP_ADD,  a: S_T0,   b: S_T1,   dst: D_T0, target: '0};
      5'd11: u = '{op: OP_DIV,  a: S_T0,   b: S_N,    dst: D_T0, target: '0};
      5'd12: u = '{op: OP_SQRT, a: S_T0,   b: S_T0,   dst: D_T1, target: '0};
      5'd13: u = '{op: OP_MUL,  a: S_NM,   b: S_NM,   dst: D_T2, target: '0};
      5'd14: u = '{op: OP_SUBZ, a: S_T0,   b: S_T2,   dst: D_T2, target: '0};
      5'd15: u = '{op: OP_SQRT, a: S_T2,   b: S_T2,   dst: D_T3, target: '0};
      5'd16: u = '{op: OP_JNH,  a: S_T0,   b: S_T0,   dst: D_T0, target: PC_DONE};
      5'd17: u = '{op: OP_MUL,  a: S_N,    b: S_HARM, dst: D_T0, target: '0};
      5'd18: u = '{op: OP_MUL,  a: S_T0,   b: S_XQ,   dst: D_T0, target: '0};
      5'd19: u = '{op: OP_MUL,  a: S_M1,   b: S_XQ,   dst: D_T2, target: '0};
      5'd20: u = '{op: OP_ADD,  a: S_T2,   b: S_HARM, dst: D_T2, target: '0};
      5'd21: u = '{op: OP_DIV,  a: S_T0,   b: S_T2,   dst: D_T0, target: '0};
      5'd22: u = '{op: OP_SATH, a: S_T0,   b: S_T0,   dst: D_T0, target: '0};
      default: u.op = OP_DONE;
    endcase
    return u;
  endfunction

  function automatic logic [VAL_BITS-1:0] sat_val(input logic [WIDE_BITS-1:0] v);
    return (v > WIDE_BITS'(VAL_MAX)) ? VAL_MAX : v[VAL_BITS-1:0];
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/running_mean_deviation_update_unit.sv
// Top level: microcoded running mean, deviation, quadratic and harmonic mean unit.
`default_nettype none
// Takes one unsigned sample at a time and returns one result per sample:
// saturating count, arithmetic mean, standard deviation, quadratic mean and
// harmonic mean (unsigned Q24.16, 40 bits) plus a harmonic valid flag. The
// prior registers are captured at the first sample after reset. A 24-step
// control program runs on bit-serial multiply, divide and square-root units
// that share one set of operand registers; the harmonic mean steps are
// skipped when the harmonic valid flag is clear. A new sample is accepted
// only once the program for the previous sample has finished and its result
// is presented. A finished result waits in the output register without
// blocking intake; a later result that finds it still held waits at the end
// of its program.
module running_mean_deviation_update_unit #(
  parameter int unsigned FRAC_BITS   = rmdu_pkg::FRAC_BITS_DEF,
  parameter int unsigned SAMPLE_BITS = rmdu_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [1:0]                     cfg_idx_i,
  input  wire logic [rmdu_pkg::CFG_BITS-1:0]  cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [SAMPLE_BITS-1:0]         sample_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic [rmdu_pkg::CNT_BITS-1:0]       sample_count_o,
  output logic [rmdu_pkg::VAL_BITS-1:0]       std_deviation_o,
  output logic [rmdu_pkg::VAL_BITS-1:0]       arith_mean_o,
  output logic [rmdu_pkg::VAL_BITS-1:0]       quad_mean_o,
  output logic [rmdu_pkg::VAL_BITS-1:0]       harm_mean_o,
  output logic                                harm_valid_o
);

  localparam int unsigned W  = rmdu_pkg::WIDE_BITS;
  localparam int unsigned VB = rmdu_pkg::VAL_BITS;
  localparam int unsigned CB = rmdu_pkg::CNT_BITS;

  logic [CB-1:0] prior_count_q;
  logic [15:0]   prior_mean_q, prior_harm_q, prior_dev_q;

  logic [CB-1:0] run_count_q;
  logic [VB-1:0] run_mean_q, run_dev_q, run_harm_q;
  logic          started_q;

  logic                          busy_q;
  logic [rmdu_pkg::PC_BITS-1:0]  pc_q;
  logic                          first_q;
  logic [rmdu_pkg::ITER_BITS-1:0] iter_q;

  logic [SAMPLE_BITS-1:0] samp_q;
  logic [CB-1:0] n_q, m1_q;
  logic [VB-1:0] xq_q, nm_q;
  logic          hvalid_q;

  logic [W-1:0] t0_q, t1_q, t2_q, t3_q;
  logic [W-1:0] x_q, y_q, acc_q;
  logic [W:0]   rem_q;

  logic [CB-1:0] out_count_q;
  logic [VB-1:0] out_dev_q, out_mean_q, out_quad_q, out_harm_q;
  logic          out_hvalid_q;
  logic          out_valid_q;

  rmdu_pkg::uop_t uop;
  logic [W-1:0]   opa, opb;
  logic           in_acc, done_go, step_adv, wr_en;
  logic [W-1:0]   wr_val;
  logic [rmdu_pkg::ITER_BITS-1:0] last_iter;

  logic [W-1:0]  mul_acc_n;
  logic [W:0]    div_rem_s, div_rem_n;
  logic          div_ge;
  logic [W:0]    sq_rem_s, sq_trial, sq_rem_n;
  logic          sq_ge;
  logic [W-1:0]  div_q_n, sq_root_n;

  logic [CB-1:0] cnt_eff;
  logic [VB-1:0] harm_eff;
  logic [63:0]   xw;

  function automatic logic [W-1:0] src_mux(input rmdu_pkg::src_e s,
      input logic [W-1:0] t0, input logic [W-1:0] t1,
      input logic [W-1:0] t2, input logic [W-1:0] t3,
      input logic [VB-1:0] mean, input logic [VB-1:0] dev,
      input logic [VB-1:0] harm, input logic [CB-1:0] n,
      input logic [CB-1:0] m1, input logic [VB-1:0] xq,
      input logic [VB-1:0] nm);
    logic [W-1:0] r;
    unique case (s)
      rmdu_pkg::S_T0:   r = t0;
      rmdu_pkg::S_T1:   r = t1;
      rmdu_pkg::S_T2:   r = t2;
      rmdu_pkg::S_T3:   r = t3;
      rmdu_pkg::S_MEAN: r = W'(mean);
      rmdu_pkg::S_DEV:  r = W'(dev);
      rmdu_pkg::S_HARM: r = W'(harm);
      rmdu_pkg::S_N:    r = W'(n);
      rmdu_pkg::S_M1:   r = W'(m1);
      rmdu_pkg::S_XQ:   r = W'(xq);
      rmdu_pkg::S_NM:   r = W'(nm);
      default:          r = '0;
    endcase
    return r;
  endfunction

  assign uop = rmdu_pkg::ucode(pc_q);
  assign opa = src_mux(uop.a, t0_q, t1_q, t2_q, t3_q, run_mean_q, run_dev_q,
                       run_harm_q, n_q, m1_q, xq_q, nm_q);
  assign opb = src_mux(uop.b, t0_q, t1_q, t2_q, t3_q, run_mean_q, run_dev_q,
                       run_harm_q, n_q, m1_q, xq_q, nm_q);

  assign in_stall_o = busy_q;
  assign in_acc     = in_valid_i && !busy_q;
  assign done_go    = busy_q && (uop.op == rmdu_pkg::OP_DONE)
                      && !(out_valid_q && out_stall_i);

  // one iteration of each serial unit
  assign mul_acc_n = y_q[0] ? (acc_q + x_q) : acc_q;

  assign div_rem_s = {rem_q[W-1:0], x_q[W-1]};
  assign div_ge    = div_rem_s >= {1'b0, y_q};
  assign div_rem_n = div_ge ? (div_rem_s - {1'b0, y_q}) : div_rem_s;
  assign div_q_n   = {acc_q[W-2:0], div_ge};

  assign sq_rem_s  = {rem_q[W-2:0], x_q[W-1:W-2]};
  assign sq_trial  = {acc_q[W-2:0], 2'b01};
  assign sq_ge     = sq_rem_s >= sq_trial;
  assign sq_rem_n  = sq_ge ? (sq_rem_s - sq_trial) : sq_rem_s;
  assign sq_root_n = {acc_q[W-2:0], sq_ge};

  assign cnt_eff  = started_q ? run_count_q : prior_count_q;
  assign harm_eff = started_q ? run_harm_q : (VB'(prior_harm_q) << FRAC_BITS);
  assign xw       = 64'(samp_q) << FRAC_BITS;

  always_comb begin
    last_iter = rmdu_pkg::MUL_LAST;
    unique case (uop.op)
      rmdu_pkg::OP_DIV:  last_iter = rmdu_pkg::DIV_LAST;
      rmdu_pkg::OP_SQRT: last_iter = rmdu_pkg::SQRT_LAST;
      default:           last_iter = rmdu_pkg::MUL_LAST;
    endcase
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_val   = '0;
    step_adv = 1'b0;
    if (busy_q) begin
      unique case (uop.op)
        rmdu_pkg::OP_MUL: begin
          if (!first_q && iter_q == last_iter) begin
            wr_en = 1'b1; wr_val = mul_acc_n; step_adv = 1'b1;
          end
        end
        rmdu_pkg::OP_DIV: begin
          if (!first_q && iter_q == last_iter) begin
            wr_en = 1'b1; wr_val = div_q_n; step_adv = 1'b1;
          end
        end
        rmdu_pkg::OP_SQRT: begin
          if (!first_q && iter_q == last_iter) begin
            wr_en = 1'b1; wr_val = sq_root_n; step_adv = 1'b1;
          end
        end
        rmdu_pkg::OP_ADD: begin
          wr_en = 1'b1; wr_val = opa + opb; step_adv = 1'b1;
        end
        rmdu_pkg::OP_SUBZ: begin
          wr_en = 1'b1; wr_val = (opa >= opb) ? (opa - opb) : '0; step_adv = 1'b1;
        end
        rmdu_pkg::OP_DONE: step_adv = 1'b0;
        default:           step_adv = 1'b1;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prior_count_q <= '0;
      prior_mean_q  <= '0;
      prior_harm_q  <= '0;
      prior_dev_q   <= '0;
      run_count_q   <= '0;
      run_mean_q    <= '0;
      run_dev_q     <= '0;
      run_harm_q    <= '0;
      started_q     <= 1'b0;
      busy_q        <= 1'b0;
      pc_q          <= '0;
      first_q       <= 1'b1;
      iter_q        <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (rmdu_pkg::reg_idx_e'(cfg_idx_i))
          rmdu_pkg::REG_PRIOR_COUNT: prior_count_q <= cfg_data_i[CB-1:0];
          rmdu_pkg::REG_PRIOR_MEAN:  prior_mean_q  <= cfg_data_i[15:0];
          rmdu_pkg::REG_PRIOR_HARM:  prior_harm_q  <= cfg_data_i[15:0];
          rmdu_pkg::REG_PRIOR_DEV:   prior_dev_q   <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (out_valid_q && !out_stall_i && !done_go) out_valid_q <= 1'b0;
      if (in_acc) begin
        busy_q  <= 1'b1;
        pc_q    <= '0;
        first_q <= 1'b1;
      end else if (busy_q) begin
        if (uop.op == rmdu_pkg::OP_INIT && !started_q) begin
          run_count_q <= prior_count_q;
          run_mean_q  <= VB'(prior_mean_q) << FRAC_BITS;
          run_dev_q   <= VB'(prior_dev_q) << FRAC_BITS;
          run_harm_q  <= VB'(prior_harm_q) << FRAC_BITS;
          started_q   <= 1'b1;
        end
        if (uop.op == rmdu_pkg::OP_SATH) run_harm_q <= rmdu_pkg::sat_val(opa);
        if (uop.op == rmdu_pkg::OP_MUL || uop.op == rmdu_pkg::OP_DIV ||
            uop.op == rmdu_pkg::OP_SQRT) begin
          if (first_q) begin
            first_q <= 1'b0;
            iter_q  <= '0;
          end else begin
            iter_q <= iter_q + 1'b1;
          end
        end
        if (step_adv) begin
          first_q <= 1'b1;
          if (uop.op == rmdu_pkg::OP_JNH && !hvalid_q) pc_q <= uop.target;
          else pc_q <= pc_q + 1'b1;
        end
        if (done_go) begin
          run_count_q <= n_q;
          run_mean_q  <= nm_q;
          run_dev_q   <= rmdu_pkg::sat_val(t3_q);
          busy_q      <= 1'b0;
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) samp_q <= sample_value_i;
    if (busy_q) begin
      if (uop.op == rmdu_pkg::OP_INIT) begin
        n_q      <= (cnt_eff == rmdu_pkg::CNT_MAX) ? cnt_eff : cnt_eff + 1'b1;
        m1_q     <= (cnt_eff == rmdu_pkg::CNT_MAX) ? cnt_eff - 1'b1 : cnt_eff;
        xq_q     <= (xw > 64'(rmdu_pkg::VAL_MAX)) ? rmdu_pkg::VAL_MAX : xw[VB-1:0];
        hvalid_q <= (prior_harm_q != '0) && (samp_q != '0) && (harm_eff != '0);
      end
      if (uop.op == rmdu_pkg::OP_SATM) nm_q <= rmdu_pkg::sat_val(opa);
      if (first_q) begin
        x_q   <= opa;
        y_q   <= opb;
        acc_q <= '0;
        rem_q <= '0;
      end else begin
        unique case (uop.op)
          rmdu_pkg::OP_MUL: begin
            acc_q <= mul_acc_n;
            x_q   <= {x_q[W-2:0], 1'b0};
            y_q   <= {1'b0, y_q[W-1:1]};
          end
          rmdu_pkg::OP_DIV: begin
            acc_q <= div_q_n;
            rem_q <= div_rem_n;
            x_q   <= {x_q[W-2:0], 1'b0};
          end
          rmdu_pkg::OP_SQRT: begin
            acc_q <= sq_root_n;
            rem_q <= sq_rem_n;
            x_q   <= {x_q[W-3:0], 2'b00};
          end
          default: ;
        endcase
      end
      if (wr_en) begin
        unique case (uop.dst)
          rmdu_pkg::D_T0: t0_q <= wr_val;
          rmdu_pkg::D_T1: t1_q <= wr_val;
          rmdu_pkg::D_T2: t2_q <= wr_val;
          rmdu_pkg::D_T3: t3_q <= wr_val;
          default: ;
        endcase
      end
    end
    if (done_go) begin
      out_count_q  <= n_q;
      out_dev_q    <= rmdu_pkg::sat_val(t3_q);
      out_mean_q   <= nm_q;
      out_quad_q   <= rmdu_pkg::sat_val(t1_q);
      out_harm_q   <= run_harm_q;
      out_hvalid_q <= hvalid_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign sample_count_o  = out_count_q;
  assign std_deviation_o = out_dev_q;
  assign arith_mean_o    = out_mean_q;
  assign quad_mean_o     = out_quad_q;
  assign harm_mean_o     = out_harm_q;
  assign harm_valid_o    = out_hvalid_q;

endmodule
`default_nettype wire
